// File: rtl/brr_pkg.sv
// brr_pkg: shared types and constants for the BRR ADPCM block decoder.
// Used by brr_front, brr_fifo, brr_back and brr_adpcm_block_decoder.
`timescale 1ns / 1ps

package brr_pkg;

	// Data bytes per block; position 0 is the header.
	localparam logic [3:0] LAST_POS = 4'd8;

	// Ranges above this saturate the nibble.
	localparam logic [3:0] RANGE_MAX = 4'd12;

	// Filter codes
	localparam logic [1:0] FILT_NONE = 2'd0;
	localparam logic [1:0] FILT_ONE  = 2'd1;
	localparam logic [1:0] FILT_TWO  = 2'd2;
	localparam logic [1:0] FILT_THREE = 2'd3;

	// Clamp limits of the undoubled sum and the value given above the upper one.
	localparam logic signed [19:0] SUM_LOW  = -20'sd32768;
	localparam logic signed [19:0] SUM_HIGH = 20'sd32767;
	localparam logic [15:0] SAMPLE_OVER = 16'hFFFE;

	// Saturated nibble for ranges above the maximum.
	localparam logic signed [15:0] NIB_SAT = -16'sd2048;

	// One data byte with the header settings of its block.
	typedef struct packed {
		logic [7:0] data;
		logic [3:0] shift_range;
		logic [1:0] filter_mode;
		logic       done;
		logic       hdr_end;
		logic       hdr_loop;
	} entry_t;

endpackage

// File: rtl/brr_front.sv
// brr_front: accepts stream bytes, parses headers and tags data bytes.
// Depends on brr_pkg.
`timescale 1ns / 1ps

module brr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     data_byte,
	input  logic           key_on,
	input  logic           full,
	output logic           push,
	output brr_pkg::entry_t push_entry
);
	import brr_pkg::*;

	logic [3:0] pos_q;
	logic [3:0] range_q;
	logic [1:0] filter_q;
	logic       end_q;
	logic       loop_q;
	logic       accept;
	logic       is_header;

	assign in_stall  = full;
	assign accept    = in_valid && !full;
	assign is_header = (pos_q == 4'd0);
	assign push      = accept && !is_header;

	assign push_entry.data        = data_byte;
	assign push_entry.shift_range = range_q;
	assign push_entry.filter_mode = filter_q;
	assign push_entry.done        = (pos_q == LAST_POS);
	assign push_entry.hdr_end     = end_q;
	assign push_entry.hdr_loop    = loop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 4'd0;
			range_q  <= 4'd0;
			filter_q <= FILT_NONE;
			end_q    <= 1'b0;
			loop_q   <= 1'b0;
		end else if (accept) begin
			if (is_header) begin
				// key-on zeroes range and filter but keeps the flags
				range_q  <= key_on ? 4'd0 : data_byte[7:4];
				filter_q <= key_on ? FILT_NONE : data_byte[3:2];
				loop_q   <= data_byte[1];
				end_q    <= data_byte[0];
				pos_q    <= 4'd1;
			end else begin
				pos_q <= (pos_q == LAST_POS) ? 4'd0 : pos_q + 4'd1;
			end
		end
	end

endmodule

// File: rtl/brr_fifo.sv
// brr_fifo: short queue of tagged data bytes between front and back.
// Depends on brr_pkg.
`timescale 1ns / 1ps

module brr_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  brr_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output brr_pkg::entry_t head_entry
);
	import brr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("brr_fifo: push while full");
	a_no_underflow : assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("brr_fifo: pop while empty");
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("brr_fifo: count beyond depth");

endmodule

// File: rtl/brr_back.sv
// brr_back: decodes the two nibbles of each queued byte, one sample a cycle while not stalled,
// into an output register. Depends on brr_pkg.
`timescale 1ns / 1ps

module brr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  brr_pkg::entry_t head_entry,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [15:0]     sample,
	output logic            last,
	output logic            block_done,
	output logic            end_flag,
	output logic            loop_flag
);
	import brr_pkg::*;

	logic               phase_q;
	logic               out_valid_q;
	logic signed [15:0] p1_q;
	logic signed [15:0] p2_q;
	logic [15:0]        sample_q;
	logic               last_q;
	logic               done_q;
	logic               end_q;
	logic               loop_q;

	logic               fire;
	logic [3:0]         nib;
	logic signed [15:0] nib_x;
	logic signed [15:0] shifted;
	logic signed [22:0] p1_x;
	logic signed [22:0] p2_x;
	logic signed [22:0] t_a;
	logic signed [22:0] t_b;
	logic signed [19:0] sum;
	logic [15:0]        result;
	logic               bd;

	assign fire = head_valid && (!out_valid_q || !out_stall);
	assign pop  = fire && phase_q;

	always_comb begin
		nib   = phase_q ? head_entry.data[3:0] : head_entry.data[7:4];
		nib_x = 16'($signed(nib));
		p1_x  = 23'(p1_q);
		p2_x  = 23'(p2_q);

		if (head_entry.shift_range == 4'd0) begin
			shifted = nib_x >>> 1;
		end else if (head_entry.shift_range <= RANGE_MAX) begin
			shifted = nib_x <<< (head_entry.shift_range - 4'd1);
		end else begin
			shifted = nib_x[15] ? NIB_SAT : 16'sd0;
		end

		unique case (head_entry.filter_mode)
			FILT_NONE: begin
				t_a = 23'sd0;
				t_b = 23'sd0;
			end
			FILT_ONE: begin
				t_a = (p1_x * 23'sd15) >>> 5;
				t_b = 23'sd0;
			end
			FILT_TWO: begin
				t_a = (p1_x * 23'sd61) >>> 6;
				t_b = (p2_x * 23'sd15) >>> 5;
			end
			FILT_THREE: begin
				t_a = (p1_x * 23'sd115) >>> 7;
				t_b = (p2_x * 23'sd13) >>> 5;
			end
			default: begin
				t_a = 23'sd0;
				t_b = 23'sd0;
			end
		endcase

		sum = 20'(shifted) + 20'(t_a) - 20'(t_b);

		// double, then saturate oddly outside the wrap window
		priority if (sum < SUM_LOW) begin
			result = 16'd0;
		end else if (sum > SUM_HIGH) begin
			result = SAMPLE_OVER;
		end else begin
			result = {sum[14:0], 1'b0};
		end

		bd = phase_q && head_entry.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			p1_q        <= 16'sd0;
			p2_q        <= 16'sd0;
		end else if (fire) begin
			phase_q     <= !phase_q;
			out_valid_q <= 1'b1;
			p1_q        <= $signed(result);
			p2_q        <= p1_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_q <= result;
			last_q   <= phase_q;
			done_q   <= bd;
			end_q    <= bd && head_entry.hdr_end;
			loop_q   <= bd && head_entry.hdr_loop;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample     = sample_q;
	assign last       = last_q;
	assign block_done = done_q;
	assign end_flag   = end_q;
	assign loop_flag  = loop_q;

	a_done_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> last_q)
		else $error("brr_back: block_done on a high nibble");
	a_flags_need_done : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (end_q || loop_q) |-> done_q)
		else $error("brr_back: flags without block_done");
	a_phase_follows : assert property (@(posedge clk) disable iff (!arst_n)
		fire && !phase_q |=> phase_q && out_valid_q && !last_q)
		else $error("brr_back: high nibble not followed by low phase");

endmodule

// File: rtl/brr_adpcm_block_decoder.sv
// BRR ADPCM block decoder, top level: front parser, item queue, sample back end.
// An accepted data byte enters the queue; the back end registers its high-nibble sample, then its low-nibble one.
// The back end gives one sample per cycle unless the output stalls or the queue is empty;
// header bytes produce no sample.
// Reset (arst_n low, asynchronous): expects a header, range/filter/flags/history zero.
// Depends on brr_pkg, brr_front, brr_fifo, brr_back.
`timescale 1ns / 1ps

module brr_adpcm_block_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        key_on,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sample,
	output logic        last,
	output logic        block_done,
	output logic        end_flag,
	output logic        loop_flag
);
	import brr_pkg::*;

	logic   full;
	logic   push;
	logic   pop;
	logic   head_valid;
	entry_t push_entry;
	entry_t head_entry;

	brr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.key_on     (key_on),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	brr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	brr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample),
		.last       (last),
		.block_done (block_done),
		.end_flag   (end_flag),
		.loop_flag  (loop_flag)
	);

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for brr_adpcm_block_decoder (BRR stream in, PCM samples out).
// A scoreboard class predicts each sample from the bytes that were accepted.
// Depends on brr_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
	import brr_pkg::*;

	typedef struct {
		logic [15:0] sample;
		logic        last;
		logic        block_done;
		logic        end_flag;
		logic        loop_flag;
	} pcm_result_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	class brr_scoreboard;
		pcm_result_t pending_samples[$];
		logic [3:0]  byte_pos;
		logic [3:0]  shift_range;
		logic [1:0]  filter_mode;
		logic        hdr_end;
		logic        hdr_loop;
		int          hist_one;
		int          hist_two;
		int          errors;
		int          samples_checked;
		int          headers_seen;

		function new();
			byte_pos = 4'd0;
			shift_range = 4'd0;
			filter_mode = FILT_NONE;
			hdr_end = 1'b0;
			hdr_loop = 1'b0;
			hist_one = 0;
			hist_two = 0;
			errors = 0;
			samples_checked = 0;
			headers_seen = 0;
		endfunction

		function logic [15:0] decode_nibble(logic [3:0] nib);
			int s;
			int r;
			int n;
			s = int'($signed(nib));
			n = int'(shift_range);
			if (n == 0) begin
				s = s >>> 1;
			end else if (n <= int'(RANGE_MAX)) begin
				s = s * (1 << (n - 1));
			end else begin
				s = (s < 0) ? -2048 : 0;
			end
			case (filter_mode)
			FILT_ONE: begin
				s += (hist_one * 15) >>> 5;
			end
			FILT_TWO: begin
				s += ((hist_one * 61) >>> 6) - ((hist_two * 15) >>> 5);
			end
			FILT_THREE: begin
				s += ((hist_one * 115) >>> 7) - ((hist_two * 13) >>> 5);
			end
			default: begin
			end
			endcase
			s = s * 2;
			// Out-of-range doubled sums clamp to 0 (low) or -2 (high), the rest wrap.
			if (s < -65536)
				r = 0;
			else if (s > 65534)
				r = -2;
			else if (s < -32768)
				r = s + 65536;
			else if (s > 32767)
				r = s - 65536;
			else
				r = s;
			hist_two = hist_one;
			hist_one = r;
			return r[15:0];
		endfunction

		function void note_byte(logic [7:0] b, logic k);
			pcm_result_t res;
			logic done;
			if (byte_pos == 4'd0) begin
				shift_range = b[7:4];
				filter_mode = b[3:2];
				hdr_end = b[0];
				hdr_loop = b[1];
				// Key-on clears range and filter but keeps flags and history.
				if (k) begin
					shift_range = 4'd0;
					filter_mode = FILT_NONE;
				end
				byte_pos = 4'd1;
				headers_seen++;
				return;
			end
			done = (byte_pos == LAST_POS);
			res.sample = decode_nibble(b[7:4]);
			res.last = 1'b0;
			res.block_done = 1'b0;
			res.end_flag = 1'b0;
			res.loop_flag = 1'b0;
			pending_samples.push_back(res);
			res.sample = decode_nibble(b[3:0]);
			res.last = 1'b1;
			res.block_done = done;
			res.end_flag = done & hdr_end;
			res.loop_flag = done & hdr_loop;
			pending_samples.push_back(res);
			byte_pos = done ? 4'd0 : byte_pos + 4'd1;
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] sample %0d: %s", $realtime, samples_checked, what);
		endtask

		task check_sample(logic [15:0] smp, logic lst, logic bd, logic ef, logic lf);
			pcm_result_t exp_res;
			if (pending_samples.size() == 0) begin
				report($sformatf("unexpected sample %h", smp));
				return;
			end
			exp_res = pending_samples.pop_front();
			if (smp !== exp_res.sample)
				report($sformatf("sample %h, predicted %h", smp, exp_res.sample));
			if (lst !== exp_res.last)
				report($sformatf("last %b, predicted %b", lst, exp_res.last));
			if (bd !== exp_res.block_done)
				report($sformatf("block_done %b, predicted %b", bd, exp_res.block_done));
			if (ef !== exp_res.end_flag)
				report($sformatf("end_flag %b, predicted %b", ef, exp_res.end_flag));
			if (lf !== exp_res.loop_flag)
				report($sformatf("loop_flag %b, predicted %b", lf, exp_res.loop_flag));
			samples_checked++;
		endtask
	endclass

	localparam int RANDOM_BLOCKS = 183;
	localparam int DIRECTED_COUNT = 27;

	// Key-on header, a range 13 block with filter 3, a range 12 block with filter 2.
	localparam logic [7:0] DIRECTED_BYTES [0:DIRECTED_COUNT-1] = '{
		8'hFF, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h88, 8'h77, 8'h01, 8'h10,
		8'hDE, 8'h87, 8'h78, 8'hF0, 8'h0F, 8'h80, 8'h08, 8'hFF, 8'h00,
		8'hC9, 8'h77, 8'h77, 8'h77, 8'h88, 8'h88, 8'h88, 8'h7F, 8'hF7
	};

	localparam logic [7:0] EXTREME_BYTES [0:7] = '{
		8'h77, 8'h88, 8'h7F, 8'hF7, 8'h80, 8'h08, 8'hFF, 8'h00
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        key_on;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] sample;
	logic        last;
	logic        block_done;
	logic        end_flag;
	logic        loop_flag;

	brr_scoreboard sb;
	int            burst_left;
	int            bytes_sent;
	stall_mode_t   stall_mode;
	int            mode_left;
	int            phase_cnt;

	brr_adpcm_block_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.key_on     (key_on),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample),
		.last       (last),
		.block_done (block_done),
		.end_flag   (end_flag),
		.loop_flag  (loop_flag)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Hold until the byte is taken; open a random gap when a burst runs out.
	task send_byte(input logic [7:0] b, input logic k);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		key_on <= k;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b, k);
		bytes_sent++;
	endtask

	task send_random_block();
		logic [7:0] b;
		int i;
		send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
		for (i = 0; i < 8; i++) begin
			if ($urandom_range(0, 3) == 0)
				b = EXTREME_BYTES[$urandom_range(0, 7)];
			else
				b = 8'($urandom_range(0, 255));
			send_byte(b, $urandom_range(0, 7) == 0);
		end
	endtask

	// Receiver stalls in modes that change at random: none, light, heavy or periodic.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 300);
		end
		mode_left--;
		phase_cnt++;
		case (stall_mode)
		STALL_NONE: begin
			out_stall <= 1'b0;
		end
		STALL_LIGHT: begin
			out_stall <= ($urandom_range(0, 99) < 30);
		end
		STALL_HEAVY: begin
			out_stall <= ($urandom_range(0, 99) < 65);
		end
		default: begin
			out_stall <= ((phase_cnt % 7) < 3);
		end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_sample(sample, last, block_done, end_flag, loop_flag);
	end

	initial begin
		int i;
		int waited;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		key_on <= 1'b0;
		out_stall <= 1'b0;
		arst_n <= 1'b0;
		sb = new();
		burst_left = 0;
		bytes_sent = 0;
		mode_left = 0;
		phase_cnt = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIRECTED_COUNT; i++)
			send_byte(DIRECTED_BYTES[i], (i == 0) || (i == 5));
		repeat (RANDOM_BLOCKS) send_random_block();
		in_valid <= 1'b0;

		waited = 0;
		while (sb.pending_samples.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending_samples.size() != 0)
			sb.report($sformatf("%0d predicted samples never came",
				sb.pending_samples.size()));

		$display("Fed %0d bytes in %0d blocks; %0d samples compared, %0d bad fields",
			bytes_sent, sb.headers_seen, sb.samples_checked, sb.errors);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
